FILE: design/atilt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atilt_pkg: shared types and constants for the accelerometer tilt block
// Widths, CORDIC arctangent table, pipeline stage types, register indexes.
// ----------------------------------------------------------------------------
package atilt_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_CELLS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int STAGE_IDX_W   = $clog2(TABLE_LEN);
  localparam int NUM_LANES     = 3;

  localparam int BYTE_W        = 8;
  localparam int SAMPLE_W      = 16;
  localparam int DIFF_W        = SAMPLE_W + 1;
  localparam int GUARD_BITS    = 8;
  localparam int DATA_W        = 28;
  localparam int ANG_W         = 25;
  localparam int OUT_W         = 15;
  localparam int Q_W           = ANG_W + 1 - GUARD_BITS;

  localparam logic signed [ANG_W-1:0] HALF_TURN_Z = ANG_W'(180 * 16384);
  localparam logic signed [ANG_W-1:0] FULL_TURN_Z = ANG_W'(360 * 16384);
  localparam logic [Q_W-1:0]          FULL_TURN_Q = Q_W'(23040);
  localparam logic [ANG_W:0]          ROUND_HALF  = (ANG_W+1)'(1) << (GUARD_BITS - 1);

  localparam int CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ZERO_OFFSET = 2'd0,
    CFG_Y_ZERO_OFFSET = 2'd1,
    CFG_Z_ZERO_OFFSET = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] u;
    logic signed [DATA_W-1:0] v;
    logic signed [ANG_W-1:0]  z;
    logic                     zero;
  } lane_t;

  typedef struct packed {
    logic                        valid;
    lane_t [NUM_LANES-1:0]       lane;
  } stage_t;

  typedef struct packed {
    logic [OUT_W-1:0] angle_about_x;
    logic [OUT_W-1:0] angle_about_y;
    logic [OUT_W-1:0] angle_about_z;
  } result_t;

  function automatic logic signed [ANG_W-1:0] atan_lookup(input logic [STAGE_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] t;
    case (idx)
      5'd0:    t = ANG_W'(737280);
      5'd1:    t = ANG_W'(435242);
      5'd2:    t = ANG_W'(229970);
      5'd3:    t = ANG_W'(116736);
      5'd4:    t = ANG_W'(58595);
      5'd5:    t = ANG_W'(29326);
      5'd6:    t = ANG_W'(14667);
      5'd7:    t = ANG_W'(7334);
      5'd8:    t = ANG_W'(3667);
      5'd9:    t = ANG_W'(1833);
      5'd10:   t = ANG_W'(917);
      5'd11:   t = ANG_W'(458);
      5'd12:   t = ANG_W'(229);
      5'd13:   t = ANG_W'(115);
      5'd14:   t = ANG_W'(57);
      5'd15:   t = ANG_W'(29);
      5'd16:   t = ANG_W'(14);
      5'd17:   t = ANG_W'(7);
      5'd18:   t = ANG_W'(4);
      5'd19:   t = ANG_W'(2);
      5'd20:   t = ANG_W'(1);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: design/atilt_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atilt_ifs: valid/ready channel interfaces
// Input frame channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface atilt_in_if import atilt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] x_low_byte;
  logic [BYTE_W-1:0] x_high_byte;
  logic [BYTE_W-1:0] y_low_byte;
  logic [BYTE_W-1:0] y_high_byte;
  logic [BYTE_W-1:0] z_low_byte;
  logic [BYTE_W-1:0] z_high_byte;

  modport source (output valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
                  z_low_byte, z_high_byte, input ready);
  modport sink   (input valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
                  z_low_byte, z_high_byte, output ready);
endinterface

interface atilt_out_if import atilt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] angle_about_x;
  logic [OUT_W-1:0] angle_about_y;
  logic [OUT_W-1:0] angle_about_z;

  modport source (output valid, angle_about_x, angle_about_y, angle_about_z, input ready);
  modport sink   (input valid, angle_about_x, angle_about_y, angle_about_z, output ready);
endinterface

interface atilt_cfg_if import atilt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SAMPLE_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/atilt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atilt_front: sample assembly and CORDIC pre-rotation
// Builds signed samples, removes offsets, scales and folds each vector
// into the right half plane.
// ----------------------------------------------------------------------------
module atilt_front import atilt_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [BYTE_W-1:0]          x_low_byte,
  input  wire logic [BYTE_W-1:0]          x_high_byte,
  input  wire logic [BYTE_W-1:0]          y_low_byte,
  input  wire logic [BYTE_W-1:0]          y_high_byte,
  input  wire logic [BYTE_W-1:0]          z_low_byte,
  input  wire logic [BYTE_W-1:0]          z_high_byte,
  input  wire logic signed [SAMPLE_W-1:0] x_offset,
  input  wire logic signed [SAMPLE_W-1:0] y_offset,
  input  wire logic signed [SAMPLE_W-1:0] z_offset,
  output      stage_t                     stage_out
);

  function automatic lane_t preset(input logic signed [DIFF_W-1:0] a,
                                   input logic signed [DIFF_W-1:0] b);
    lane_t l;
    logic signed [DATA_W-1:0] as;
    logic signed [DATA_W-1:0] bs;
    as = DATA_W'(a) <<< GUARD_BITS;
    bs = DATA_W'(b) <<< GUARD_BITS;
    l.zero = (a == '0) && (b == '0);
    if (b[DIFF_W-1]) begin
      l.u = -bs;
      l.v = -as;
      l.z = HALF_TURN_Z;
    end else begin
      l.u = bs;
      l.v = as;
      l.z = '0;
    end
    return l;
  endfunction

  logic signed [DIFF_W-1:0] dx, dy, dz;
  stage_t stage_r, stage_nxt;

  always_comb begin
    dx = DIFF_W'($signed({x_high_byte, x_low_byte})) - DIFF_W'(x_offset);
    dy = DIFF_W'($signed({y_high_byte, y_low_byte})) - DIFF_W'(y_offset);
    dz = DIFF_W'($signed({z_high_byte, z_low_byte})) - DIFF_W'(z_offset);
    stage_nxt.valid   = in_valid;
    stage_nxt.lane[0] = preset(dy, dz);
    stage_nxt.lane[1] = preset(dx, dz);
    stage_nxt.lane[2] = preset(dy, dx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule
`default_nettype wire

FILE: design/atilt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atilt_cell: one CORDIC vectoring micro-rotation for all three lanes
// Rotates toward the x axis by atan(2^-i) and passes the beat on.
// ----------------------------------------------------------------------------
module atilt_cell import atilt_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic [STAGE_IDX_W-1:0] stage_idx,
  input  wire stage_t                 stage_in,
  output      stage_t                 stage_out
);

  stage_t stage_r, stage_nxt;
  logic signed [ANG_W-1:0] step_ang;

  always_comb begin
    step_ang        = atan_lookup(stage_idx);
    stage_nxt.valid = stage_in.valid;
    for (int l = 0; l < NUM_LANES; l++) begin
      stage_nxt.lane[l].zero = stage_in.lane[l].zero;
      if (!stage_in.lane[l].v[DATA_W-1]) begin
        stage_nxt.lane[l].u = stage_in.lane[l].u + (stage_in.lane[l].v >>> stage_idx);
        stage_nxt.lane[l].v = stage_in.lane[l].v - (stage_in.lane[l].u >>> stage_idx);
        stage_nxt.lane[l].z = stage_in.lane[l].z + step_ang;
      end else begin
        stage_nxt.lane[l].u = stage_in.lane[l].u - (stage_in.lane[l].v >>> stage_idx);
        stage_nxt.lane[l].v = stage_in.lane[l].v + (stage_in.lane[l].u >>> stage_idx);
        stage_nxt.lane[l].z = stage_in.lane[l].z - step_ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule
`default_nettype wire

FILE: design/atilt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// atilt_back: angle wrap, rounding and output register
// Wraps the accumulator into one turn, rounds to 1/64 degree and holds the
// result beat until taken.
// ----------------------------------------------------------------------------
module atilt_back import atilt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   en,
  input  wire stage_t stage_in,
  output      logic   out_valid,
  output      result_t result
);

  function automatic logic [OUT_W-1:0] finish(input lane_t l);
    logic signed [ANG_W-1:0] zz;
    logic [ANG_W:0]          sum;
    logic [Q_W-1:0]          q;
    zz  = l.z[ANG_W-1] ? (l.z + FULL_TURN_Z) : l.z;
    sum = {1'b0, zz} + ROUND_HALF;
    q   = sum[ANG_W:GUARD_BITS];
    if (q >= FULL_TURN_Q) begin
      q = q - FULL_TURN_Q;
    end
    if (l.zero) begin
      q = '0;
    end
    return q[OUT_W-1:0];
  endfunction

  logic    out_valid_r;
  result_t result_r, result_nxt;

  always_comb begin
    result_nxt.angle_about_x = finish(stage_in.lane[0]);
    result_nxt.angle_about_y = finish(stage_in.lane[1]);
    result_nxt.angle_about_z = finish(stage_in.lane[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule
`default_nettype wire

FILE: design/accel_tilt_angles.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_angles: tilt angles from one accelerometer frame
// Three atan2 angles in 1/64 degree from offset-corrected x, y, z samples.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  in_ch    in   six raw bytes, low byte first per axis
//  out_ch   out  angle_about_x, angle_about_y, angle_about_z
//  cfg_ch   in   register index and 16-bit offset
//
//  One frame per cycle unless the result stalls. The pipe is a front stage,
//  one cell per micro-rotation and an output register.
//  Reset clears the offsets and all beat valids; cfg_ch is always ready.
//  A stalled result holds the whole pipe, and in_ch ready drops with it.
// ----------------------------------------------------------------------------
module accel_tilt_angles import atilt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  atilt_in_if.sink   in_ch,
  atilt_out_if.source out_ch,
  atilt_cfg_if.sink  cfg_ch
);

  logic signed [SAMPLE_W-1:0] x_offset_r, y_offset_r, z_offset_r;
  logic    en;
  logic    out_valid;
  result_t result;
  stage_t  chain [0:NUM_CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_offset_r <= '0;
      y_offset_r <= '0;
      z_offset_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_X_ZERO_OFFSET: x_offset_r <= cfg_ch.data;
        CFG_Y_ZERO_OFFSET: y_offset_r <= cfg_ch.data;
        CFG_Z_ZERO_OFFSET: z_offset_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign en           = !out_valid || out_ch.ready;
  assign in_ch.ready  = en;

  atilt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_ch.valid),
    .x_low_byte  (in_ch.x_low_byte),
    .x_high_byte (in_ch.x_high_byte),
    .y_low_byte  (in_ch.y_low_byte),
    .y_high_byte (in_ch.y_high_byte),
    .z_low_byte  (in_ch.z_low_byte),
    .z_high_byte (in_ch.z_high_byte),
    .x_offset    (x_offset_r),
    .y_offset    (y_offset_r),
    .z_offset    (z_offset_r),
    .stage_out   (chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    atilt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .stage_idx (STAGE_IDX_W'(i)),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  atilt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .stage_in  (chain[NUM_CELLS]),
    .out_valid (out_valid),
    .result    (result)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.angle_about_x = result.angle_about_x;
  assign out_ch.angle_about_y = result.angle_about_y;
  assign out_ch.angle_about_z = result.angle_about_z;

endmodule
`default_nettype wire

FILE: sim/tb_accel_tilt_angles.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_tilt_angles: self-checking bench for accel_tilt_angles
// A directed table of axis extremes, then random frames under several offset
// settings with idling on both channels and a long result stall. Every result
// beat is compared, angle by angle, with an in-bench CORDIC predictor or a typed table row.
// ----------------------------------------------------------------------------
module tb_accel_tilt_angles;
  import atilt_pkg::*;

  localparam int     LATENCY       = CORDIC_STAGES + 2;
  localparam int     ITEMS_PER_SET = 160;
  localparam int     NUM_SETS      = 6;
  localparam int     HOLD_CYCLES   = 200;
  localparam int     STALL_LIMIT   = 3000;
  localparam longint DEG_UNITS     = 16384;
  localparam longint GUARD_SCALE   = longint'(1) << GUARD_BITS;
  localparam longint OUT_TURN      = 23040;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // atan(2^-i) in 1/16384 degree
  localparam longint MICRO_ROT [TABLE_LEN] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0, 0, 0
  };

  typedef struct packed {
    logic [BYTE_W-1:0] x_lo;
    logic [BYTE_W-1:0] x_hi;
    logic [BYTE_W-1:0] y_lo;
    logic [BYTE_W-1:0] y_hi;
    logic [BYTE_W-1:0] z_lo;
    logic [BYTE_W-1:0] z_hi;
  } frame_t;

  typedef struct packed {
    logic                typed;
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] z;
    result_t             want;
  } dir_row_t;

  localparam result_t ZERO_ANGLES = '0;
  localparam int      NUM_DIR     = 22;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{1'b1, 16'h0000, 16'h0000, 16'h0000, ZERO_ANGLES},
    '{1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, ZERO_ANGLES},
    '{1'b0, 16'h8000, 16'h8000, 16'h8000, ZERO_ANGLES},
    '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, ZERO_ANGLES},
    '{1'b0, 16'h0001, 16'h0001, 16'h0001, ZERO_ANGLES},
    '{1'b0, 16'h0000, 16'h0000, 16'hFFFF, ZERO_ANGLES},
    '{1'b0, 16'h0000, 16'h0000, 16'h8000, ZERO_ANGLES},
    '{1'b0, 16'h8000, 16'h0000, 16'h0000, ZERO_ANGLES},
    '{1'b0, 16'h0000, 16'h0000, 16'h7FFF, ZERO_ANGLES},
    '{1'b0, 16'h7FFF, 16'h0000, 16'h0000, ZERO_ANGLES},
    '{1'b0, 16'h0000, 16'h7FFF, 16'h0000, ZERO_ANGLES},
    '{1'b0, 16'h0000, 16'h8000, 16'h0000, ZERO_ANGLES},
    '{1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, ZERO_ANGLES},
    '{1'b0, 16'h8000, 16'h7FFF, 16'h8000, ZERO_ANGLES},
    '{1'b0, 16'h00FF, 16'hFF00, 16'h00FF, ZERO_ANGLES},
    '{1'b0, 16'hFF00, 16'h00FF, 16'hFF00, ZERO_ANGLES},
    '{1'b0, 16'h5555, 16'hAAAA, 16'h5555, ZERO_ANGLES},
    '{1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, ZERO_ANGLES},
    '{1'b0, 16'h0001, 16'hFFFF, 16'h0000, ZERO_ANGLES},
    '{1'b0, 16'h0000, 16'h0001, 16'hFFFF, ZERO_ANGLES},
    '{1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, ZERO_ANGLES},
    '{1'b1, 16'h0000, 16'h0000, 16'h0000, ZERO_ANGLES}
  };

  logic clk;
  logic rst_n;

  atilt_in_if  in_bus ();
  atilt_out_if out_bus ();
  atilt_cfg_if cfg_bus ();

  accel_tilt_angles u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  logic signed [SAMPLE_W-1:0] x_off;
  logic signed [SAMPLE_W-1:0] y_off;
  logic signed [SAMPLE_W-1:0] z_off;

  result_t pending_angles [$];
  int      mismatches   = 0;
  int      src_idle_pct = 0;
  int      snk_idle_pct = 0;
  bit      hold_req     = 1'b0;

  function automatic logic [OUT_W-1:0] cordic_angle(input longint num, input longint den);
    longint          u;
    longint          v;
    longint          acc;
    longint          du;
    longint          dv;
    longint unsigned q;
    if (num == 0 && den == 0) return '0;
    if (den < 0) begin
      u   = -den * GUARD_SCALE;
      v   = -num * GUARD_SCALE;
      acc = 180 * DEG_UNITS;
    end else begin
      u   = den * GUARD_SCALE;
      v   = num * GUARD_SCALE;
      acc = 0;
    end
    for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
      du = v >>> i;
      dv = u >>> i;
      if (v >= 0) begin
        u   = u + du;
        v   = v - dv;
        acc = acc + MICRO_ROT[i];
      end else begin
        u   = u - du;
        v   = v + dv;
        acc = acc - MICRO_ROT[i];
      end
    end
    if (acc < 0) acc = acc + 360 * DEG_UNITS;
    q = ($unsigned(acc) + $unsigned(GUARD_SCALE / 2)) >> GUARD_BITS;
    if (q >= OUT_TURN) q = q - OUT_TURN;
    return OUT_W'(q);
  endfunction

  function automatic result_t predict_angles(input frame_t f);
    longint  dx;
    longint  dy;
    longint  dz;
    result_t r;
    dx = longint'($signed({f.x_hi, f.x_lo})) - longint'(x_off);
    dy = longint'($signed({f.y_hi, f.y_lo})) - longint'(y_off);
    dz = longint'($signed({f.z_hi, f.z_lo})) - longint'(z_off);
    r.angle_about_x = cordic_angle(dy, dz);
    r.angle_about_y = cordic_angle(dx, dz);
    r.angle_about_z = cordic_angle(dy, dx);
    return r;
  endfunction

  function automatic frame_t pack_frame(input logic [SAMPLE_W-1:0] x, y, z);
    return '{x[7:0], x[15:8], y[7:0], y[15:8], z[7:0], z[15:8]};
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_axis(input logic [SAMPLE_W-1:0] off);
    int                  pick;
    logic [SAMPLE_W-1:0] s;
    pick = $urandom_range(99);
    if (pick < 50) begin
      s = SAMPLE_W'($urandom);
    end else if (pick < 65) begin
      s = off + SAMPLE_W'($urandom_range(6)) - SAMPLE_W'(3);
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0: s = 16'h7FFF;
        1: s = 16'h8000;
        2: s = 16'h0000;
        default: s = 16'hFFFF;
      endcase
    end else begin
      s = off;
    end
    return s;
  endfunction

  // valid stays high from one beat to the next unless a gap is drawn
  task automatic send_beat(input frame_t f, input logic typed, input result_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.x_low_byte  <= f.x_lo;
    in_bus.x_high_byte <= f.x_hi;
    in_bus.y_low_byte  <= f.y_lo;
    in_bus.y_high_byte <= f.y_hi;
    in_bus.z_low_byte  <= f.z_lo;
    in_bus.z_high_byte <= f.z_hi;
    do @(posedge clk); while (!in_bus.ready);
    pending_angles.push_back(typed ? want : predict_angles(f));
  endtask

  task automatic write_offset(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_X_ZERO_OFFSET: x_off = val;
      CFG_Y_ZERO_OFFSET: y_off = val;
      CFG_Z_ZERO_OFFSET: z_off = val;
      default: ;
    endcase
  endtask

  task automatic load_offsets(input logic [SAMPLE_W-1:0] x, y, z, input bit poke_unused);
    write_offset(CFG_X_ZERO_OFFSET, x);
    write_offset(CFG_Y_ZERO_OFFSET, y);
    write_offset(CFG_Z_ZERO_OFFSET, z);
    if (poke_unused) write_offset(CFG_UNUSED_IDX, SAMPLE_W'($urandom));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    wait (pending_angles.size() == 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic check_angle(input string field, input logic [OUT_W-1:0] want, got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result receiver; a hold request stalls it for a long counted stretch
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_a;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_angles.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat x=%0d y=%0d z=%0d", $time,
                 out_bus.angle_about_x, out_bus.angle_about_y, out_bus.angle_about_z);
      end else begin
        exp_a = pending_angles.pop_front();
        check_angle("angle_about_x", exp_a.angle_about_x, out_bus.angle_about_x);
        check_angle("angle_about_y", exp_a.angle_about_y, out_bus.angle_about_y);
        check_angle("angle_about_z", exp_a.angle_about_z, out_bus.angle_about_z);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_accel_tilt_angles: errors");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.x_low_byte  <= '0;
    in_bus.x_high_byte <= '0;
    in_bus.y_low_byte  <= '0;
    in_bus.y_high_byte <= '0;
    in_bus.z_low_byte  <= '0;
    in_bus.z_high_byte <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= CFG_X_ZERO_OFFSET;
    cfg_bus.data       <= '0;
    x_off = '0;
    y_off = '0;
    z_off = '0;
    src_idle_pct = 13;
    snk_idle_pct = 71;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      send_beat(pack_frame(DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].z),
                DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    for (int p = 0; p < NUM_SETS; p++) begin
      settle();
      case (p)
        0: load_offsets(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        1: load_offsets(16'h8000, 16'h8000, 16'h8000, 1'b0);
        2: load_offsets(16'h7FFF, 16'h8000, 16'h0000, 1'b1);
        4: load_offsets(16'h0000, 16'h0000, 16'h0000, 1'b0);
        default: load_offsets(SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                              SAMPLE_W'($urandom), p == 5);
      endcase
      src_idle_pct = (p < 2) ? 13 : (p < 4) ? 71 : 0;
      snk_idle_pct = (p < 2) ? 71 : (p < 4) ? 13 : 0;
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        if (p == 1 && n == ITEMS_PER_SET / 2) begin
          in_bus.valid <= 1'b0;
          wait (pending_angles.size() == 0);
          @(posedge clk);
        end
        if (p == 4 && n == 40) hold_req = 1'b1;
        send_beat(pack_frame(random_axis(x_off), random_axis(y_off), random_axis(z_off)),
                  1'b0, ZERO_ANGLES);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_accel_tilt_angles: clean");
    end else begin
      $display("tb_accel_tilt_angles: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/atilt_pkg.sv
design/atilt_ifs.sv
design/atilt_front.sv
design/atilt_cell.sv
design/atilt_back.sv
design/accel_tilt_angles.sv
sim/tb_accel_tilt_angles.sv
